/* hdl/m2i_pkg.sv */
package m2i_pkg;

    localparam int ELEM_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int IO_WIDTH       = 32;
    localparam int DET_WIDTH      = 64;
    localparam int LANES          = 4;

    typedef struct packed {
        logic [IO_WIDTH-1:0] a00;
        logic [IO_WIDTH-1:0] a10;
        logic [IO_WIDTH-1:0] a01;
        logic [IO_WIDTH-1:0] a11;
    } t_mat;

    typedef struct packed {
        logic [DET_WIDTH-1:0] determinant;
        logic [IO_WIDTH-1:0]  inv00;
        logic [IO_WIDTH-1:0]  inv10;
        logic [IO_WIDTH-1:0]  inv01;
        logic [IO_WIDTH-1:0]  inv11;
        logic                 singular;
        logic                 saturated;
    } t_res;

    // Per-lane status handed to the merge stage.
    typedef struct packed {
        logic valid;
        logic sat;
    } t_lane_stat;

endpackage

/* hdl/m2i_if.sv */
interface m2i_in_if;
    import m2i_pkg::*;
    logic valid;
    logic ready;
    t_mat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface m2i_out_if;
    import m2i_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/m2i_det.sv */
module m2i_det #(
    parameter int ELEM_WIDTH = m2i_pkg::ELEM_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  m2i_pkg::t_mat                  i_mat,
    output logic signed [ELEM_WIDTH-1:0]   o_e [4],
    output logic signed [2*ELEM_WIDTH-1:0] o_det
);
    import m2i_pkg::*;

    localparam int PW = 2 * ELEM_WIDTH;

    logic signed [ELEM_WIDTH-1:0] r_e  [4];
    logic signed [ELEM_WIDTH-1:0] r_e2 [4];
    logic signed [PW-1:0]         r_p0, r_p1;
    logic signed [PW-1:0]         r_det;
    logic signed [ELEM_WIDTH-1:0] n_e  [4];

    assign n_e[0] = i_mat.a00[ELEM_WIDTH-1:0];
    assign n_e[1] = i_mat.a10[ELEM_WIDTH-1:0];
    assign n_e[2] = i_mat.a01[ELEM_WIDTH-1:0];
    assign n_e[3] = i_mat.a11[ELEM_WIDTH-1:0];

    // Stage 1 registers elements, stage 2 both products, stage 3 the difference.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e   <= n_e;
            r_p0  <= PW'(r_e[0]) * PW'(r_e[3]);
            r_p1  <= PW'(r_e[2]) * PW'(r_e[1]);
            r_e2  <= r_e;
            r_det <= r_p0 - r_p1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_e <= r_e2;
        end
    end

    assign o_det = r_det;

endmodule

/* hdl/m2i_lane.sv */
module m2i_lane #(
    parameter int ELEM_WIDTH = m2i_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = m2i_pkg::FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [ELEM_WIDTH-1:0]   i_num_mag,
    input  logic                    i_neg,
    input  logic [2*ELEM_WIDTH-1:0] i_den_mag,
    output logic [ELEM_WIDTH-1:0]   o_q,
    output logic                    o_sat
);
    import m2i_pkg::*;

    // Pipelined restoring divider, one quotient bit per stage. Only the
    // quotient bits that can fall inside range are developed; a set bit
    // above them forces saturation.
    localparam int DW = 2 * ELEM_WIDTH;
    localparam int NW = ELEM_WIDTH + 2 * FRAC_BITS;
    localparam int QB = ELEM_WIDTH + 1;
    localparam int RW = DW + 1;
    localparam int CW = (NW > DW) ? NW : DW;

    logic [RW-1:0]         r_rem  [QB+1];
    logic [NW-1:0]         r_num  [QB+1];
    logic [DW-1:0]         r_den  [QB+1];
    logic [QB-1:0]         r_q    [QB+1];
    logic                  r_neg  [QB+1];
    logic                  r_big  [QB+1];
    logic [ELEM_WIDTH-1:0] r_out;
    logic                  r_sat;
    logic [NW-1:0]         n_num;

    assign n_num = NW'(i_num_mag) << (2 * FRAC_BITS);

    // Stage 0: decide overflow from the high numerator part. num/den with
    // quotient >= 2^QB iff (num >> QB) >= den.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= n_num;
            r_den[0] <= i_den_mag;
            r_neg[0] <= i_neg && (i_num_mag != '0);
            r_big[0] <= CW'(n_num >> QB) >= CW'(i_den_mag);
            r_rem[0] <= RW'(n_num >> QB);
            r_q[0]   <= '0;
        end
    end

    for (genvar s = 0; s < QB; s++) begin : g_stage
        logic [RW-1:0] n_sh;
        logic          n_ge;
        always_comb begin
            n_sh = {r_rem[s][RW-2:0], r_num[s][QB-1-s]};
            n_ge = n_sh >= RW'(r_den[s]);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= n_ge ? n_sh - RW'(r_den[s]) : n_sh;
                r_q[s+1]   <= {r_q[s][QB-2:0], n_ge};
                r_num[s+1] <= r_num[s];
                r_den[s+1] <= r_den[s];
                r_neg[s+1] <= r_neg[s];
                r_big[s+1] <= r_big[s];
            end
        end
    end

    localparam logic [QB-1:0] LIM_POS = QB'((64'd1 << (ELEM_WIDTH - 1)) - 64'd1);
    localparam logic [QB-1:0] LIM_NEG = QB'(64'd1 << (ELEM_WIDTH - 1));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_neg[QB]) begin
                if (r_big[QB] || r_q[QB] > LIM_NEG) begin
                    r_out <= LIM_NEG[ELEM_WIDTH-1:0];
                    r_sat <= 1'b1;
                end else begin
                    r_out <= ELEM_WIDTH'(~r_q[QB] + 1'b1);
                    r_sat <= 1'b0;
                end
            end else begin
                if (r_big[QB] || r_q[QB] > LIM_POS) begin
                    r_out <= LIM_POS[ELEM_WIDTH-1:0];
                    r_sat <= 1'b1;
                end else begin
                    r_out <= r_q[QB][ELEM_WIDTH-1:0];
                    r_sat <= 1'b0;
                end
            end
        end
    end

    assign o_q   = r_out;
    assign o_sat = r_sat;

endmodule

/* hdl/matrix2x2_inverse.sv */
// Channel   Dir   Payload
// i_in      in    a00, a10, a01, a11 (t_mat)
// o_out     out   determinant, inv00..inv11, singular, saturated (t_res)
// One matrix per cycle sustained while o_out is not stalled; a result is offered
// once its item has passed the determinant pipeline, the bit-per-stage divider
// pipeline in each of the four lanes and the merge stage.
// Reset clears only the valid bits: skid, pipeline and output.
// A stalled output freezes the whole pipeline; a skid register keeps
// i_in.ready from depending combinationally on o_out.ready.
module matrix2x2_inverse #(
    parameter int ELEM_WIDTH = m2i_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = m2i_pkg::FRAC_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    m2i_in_if.sink    i_in,
    m2i_out_if.source o_out
);
    import m2i_pkg::*;

    localparam int DW  = 2 * ELEM_WIDTH;
    localparam int LAT = 3 + ELEM_WIDTH + 3;

    logic en;
    logic [LAT-1:0] r_vld;
    logic r_skid_v, r_out_v;
    t_mat r_skid;
    t_mat cur;
    logic cur_v;

    assign en = !r_out_v || o_out.ready;
    assign i_in.ready = !r_skid_v;
    assign cur   = r_skid_v ? r_skid : i_in.data;
    assign cur_v = r_skid_v || i_in.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (!en && i_in.valid && i_in.ready) begin
            r_skid_v <= 1'b1;
        end else if (en) begin
            r_skid_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!en && i_in.valid && i_in.ready) begin
            r_skid <= i_in.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], cur_v};
        end
    end

    logic signed [ELEM_WIDTH-1:0] e [4];
    logic signed [DW-1:0]         det;

    m2i_det #(.ELEM_WIDTH(ELEM_WIDTH)) u_det (
        .i_clk(i_clk), .i_en(en), .i_mat(cur), .o_e(e), .o_det(det)
    );

    // Lane k divides adj element by det: inv00=a11, inv10=-a10, inv01=-a01,
    // inv11=a00.
    logic [ELEM_WIDTH-1:0] l_mag [LANES];
    logic                  l_neg [LANES];
    logic [ELEM_WIDTH-1:0] l_q   [LANES];
    t_lane_stat            l_st  [LANES];
    logic [DW-1:0]         dmag;
    logic                  dneg;

    assign dneg = det[DW-1];
    assign dmag = dneg ? DW'(-det) : DW'(det);

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            logic signed [ELEM_WIDTH-1:0] v;
            v = e[(k == 0) ? 3 : (k == 3) ? 0 : k];
            l_mag[k] = v[ELEM_WIDTH-1] ? ELEM_WIDTH'(-v) : ELEM_WIDTH'(v);
        end
        l_neg[0] = e[3][ELEM_WIDTH-1] != dneg;
        l_neg[1] = (e[1] > 0) != dneg;
        l_neg[2] = (e[2] > 0) != dneg;
        l_neg[3] = e[0][ELEM_WIDTH-1] != dneg;
    end

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        logic sat;
        m2i_lane #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk(i_clk), .i_en(en), .i_num_mag(l_mag[k]), .i_neg(l_neg[k]),
            .i_den_mag(dmag), .o_q(l_q[k]), .o_sat(sat)
        );
        assign l_st[k].valid = r_vld[LAT-1];
        assign l_st[k].sat   = sat;
    end

    // Determinant delay line matching the lanes.
    localparam int DL = ELEM_WIDTH + 3;
    logic [DW-1:0] r_dline [DL];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dline[0] <= DW'(det);
            for (int i = 1; i < DL; i++) r_dline[i] <= r_dline[i-1];
        end
    end

    // Merge stage.
    t_res r_res;
    logic n_sing;
    assign n_sing = r_dline[DL-1] == '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= l_st[0].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res.determinant <= DET_WIDTH'($signed(r_dline[DL-1]));
            r_res.singular    <= n_sing;
            r_res.inv00 <= n_sing ? '0 : IO_WIDTH'($signed(l_q[0]));
            r_res.inv10 <= n_sing ? '0 : IO_WIDTH'($signed(l_q[1]));
            r_res.inv01 <= n_sing ? '0 : IO_WIDTH'($signed(l_q[2]));
            r_res.inv11 <= n_sing ? '0 : IO_WIDTH'($signed(l_q[3]));
            r_res.saturated <= !n_sing && (l_st[0].sat || l_st[1].sat
                                           || l_st[2].sat || l_st[3].sat);
        end
    end

    assign o_out.valid = r_out_v;
    assign o_out.data  = r_res;

`ifndef SYNTHESIS
    a_sing_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.singular |-> !o_out.data.saturated
            && o_out.data.inv00 == '0 && o_out.data.inv11 == '0)
        else $error("singular result with nonzero inverse");
    a_sing_det: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.data.singular == (o_out.data.determinant == '0))
        else $error("singular flag disagrees with determinant");
    a_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> !i_in.ready)
        else $error("skid full but input ready");
`endif

endmodule
